// ===== sv/modular_secret_transform_defines.svh =====
// Assertion macros used by the modular secret transform RTL.
`ifndef MODULAR_SECRET_TRANSFORM_DEFINES_SVH
`define MODULAR_SECRET_TRANSFORM_DEFINES_SVH

// Assert that a property holds at every clock edge outside reset.
`define MST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a consequent follows an antecedent.
`define MST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/mst_pkg.sv =====
`default_nettype none
package mst_pkg;
  localparam int MaxDim = 64;
  localparam int ValueBits = 15;
  localparam int QW = 15;
  localparam int DimW = 7;

  localparam logic [1:0] ACT_MAT = 2'd0;
  localparam logic [1:0] ACT_OFF = 2'd1;
  localparam logic [1:0] ACT_VEC = 2'd2;
  localparam logic [1:0] ACT_RUN = 2'd3;

  localparam logic [1:0] REG_DIM = 2'd0;
  localparam logic [1:0] REG_MOD = 2'd1;
  localparam logic [1:0] REG_DIR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // a load word is being reduced
    logic red_start; // start the modular reducer
    logic pre_rd;    // read vector and offset at element index
    logic pre_wr;    // write working copy element
    logic off_rd;    // reduce the offset of the current row
    logic mac_clr;   // clear accumulator
    logic mac_rd;    // read matrix and working entry
    logic mac_acc;   // accumulate product
    logic fin;       // finalize row
    logic emit;      // present result and write back
  } mst_cmd_t;

  typedef struct packed {
    logic red_done;
  } mst_sts_t;
endpackage
`default_nettype wire

// ===== sv/modular_secret_transform.sv =====
// A load keeps busy high while the bit-serial mod-q reducer works through its
// 46-bit input and signals done; a new load is taken once busy is low again.
// A compute keeps busy high while it builds the working copy element by element,
// then per row reduces the offset, walks the products, and ends with the
// final reduction and the emit. Results come one per row, one cycle each.
// The receiver cannot stall. rst_n is synchronous, active low; it restores
// the registers and idles the controller, the stores stay undefined.
`default_nettype none
module modular_secret_transform import mst_pkg::*; #(
  parameter int MAX_DIM = MaxDim,
  parameter int VALUE_BITS = ValueBits
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [5:0]  in_row,
  input  wire logic [5:0]  in_col,
  input  wire logic [14:0] in_value,
  output logic             out_strobe,
  output logic [5:0]       out_index,
  output logic [14:0]      out_result_value,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int AW = $clog2(MAX_DIM);
  logic [DimW-1:0] dim_r;
  logic [QW-1:0]   q_r;
  logic            dir_r;
  mst_cmd_t        cmd;
  mst_sts_t        sts;
  logic [AW-1:0]   ei, ej;
  logic            emit, last;
  logic [14:0]     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DimW'(64);
      q_r <= QW'(32749);
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM: dim_r <= cfg_data[DimW-1:0];
        REG_MOD: q_r <= cfg_data;
        REG_DIR: dir_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mst_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .action(in_action), .dim(dim_r),
    .busy(busy), .sts(sts), .cmd(cmd), .ei(ei), .ej(ej), .emit(emit), .last(last)
  );

  mst_datapath #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .action(in_action),
    .row(in_row), .col(in_col), .value(in_value), .ei(ei), .ej(ej),
    .q(q_r), .inv(dir_r), .res_value(res)
  );

  assign out_strobe = emit;
  assign out_index = 6'(ei);
  assign out_result_value = res;
  assign out_last = last;
endmodule
`default_nettype wire

// ===== sv/mst_ram.sv =====
`default_nettype none
module mst_ram #(
  parameter int Width = 15,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/mst_modred.sv =====
`default_nettype none
// Restoring reduction of a wide value modulo q, one bit per cycle.
module mst_modred import mst_pkg::*; #(
  parameter int InW = 46
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [InW-1:0] din,
  input  wire logic [QW-1:0]  q,
  output logic                done,
  output logic [QW-1:0]       rem
);
  localparam int CntW = $clog2(InW + 1);
  logic [InW-1:0]  sh_r, sh_nxt;
  logic [QW:0]     acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [QW+1:0]   trial;

  always_comb begin
    sh_nxt = sh_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {acc_r, sh_r[InW-1]} - {2'b00, q};
    if (start) begin
      sh_nxt = din;
      acc_nxt = '0;
      cnt_nxt = CntW'(InW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt = {sh_r[InW-2:0], 1'b0};
      if (!trial[QW+1]) begin
        acc_nxt = trial[QW:0];
      end else begin
        acc_nxt = {acc_r[QW-1:0], sh_r[InW-1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign rem = acc_r[QW-1:0];
endmodule
`default_nettype wire

// ===== sv/mst_datapath.sv =====
`default_nettype none
module mst_datapath import mst_pkg::*; #(
  parameter int MAX_DIM = MaxDim,
  parameter int VALUE_BITS = ValueBits
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mst_cmd_t           cmd,
  output mst_sts_t                sts,
  input  wire logic [1:0]         action,
  input  wire logic [5:0]         row,
  input  wire logic [5:0]         col,
  input  wire logic [14:0]        value,
  input  wire logic [$clog2(MAX_DIM)-1:0] ei,
  input  wire logic [$clog2(MAX_DIM)-1:0] ej,
  input  wire logic [QW-1:0]      q,
  input  wire logic               inv,
  output logic [14:0]             res_value
);
  localparam int AW = $clog2(MAX_DIM);
  localparam int AccW = 2 * QW + 16;
  localparam logic [QW-1:0] OneQ = QW'(1);

  // Operands are reduced again by the current q, so widths hold any stored value.
  logic [QW-1:0] q_eff;
  assign q_eff = (q < 15'd2) ? OneQ : q;

  logic [1:0]      act_r;
  logic [AW-1:0]   row_r, col_r;
  logic            ok_r;
  logic [AccW-1:0] red_in, acc_r, acc_nxt;
  logic            red_done;
  logic [QW-1:0]   red_rem;
  logic [QW-1:0]   v_rd, o_rd, m_rd, w_rd;
  logic [QW-1:0]   vmod_r, omod_r;
  logic [2:0]      phase_r;
  logic [29:0]     prod_r;
  logic            prod_v_r;
  logic            vwe, owe, mwe, wwe;
  logic [QW-1:0]   vwd, wwd;
  logic [AW-1:0]   vwa;

  // Operand sequencing through the shared reducer: 0 vector, 1 offset,
  // 2 pre-sum or row sum, 3 matrix, 4 load word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      row_r <= AW'(row);
      col_r <= AW'(col);
      ok_r <= (32'(row) < MAX_DIM) && (action != ACT_MAT || 32'(col) < MAX_DIM);
    end
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.red_start) begin
      phase_r <= cmd.mac_rd ? 3'd3 : (cmd.pre_rd ? 3'd0 : (cmd.off_rd ? 3'd1 :
                 (cmd.fin ? 3'd2 : (cmd.load ? 3'd4 : phase_r + 3'd1))));
    end
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= cmd.mac_acc;
    end
    if (red_done) begin
      case (phase_r)
        3'd0: vmod_r <= red_rem;
        3'd1: omod_r <= red_rem;
        default: ;
      endcase
    end
    if (cmd.mac_acc) begin
      prod_r <= red_rem * w_rd;
    end
    acc_r <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.mac_clr) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + AccW'(prod_r);
    end
  end

  // Reducer input per phase.
  always_comb begin
    red_in = '0;
    if (cmd.load) begin
      red_in = AccW'(value & 15'((1 << VALUE_BITS) - 1));
    end else if (cmd.mac_rd) begin
      red_in = AccW'(m_rd);
    end else if (cmd.pre_rd) begin
      red_in = AccW'(v_rd);
    end else if (cmd.off_rd) begin
      red_in = AccW'(o_rd);
    end else if (cmd.fin) begin
      red_in = inv ? acc_r + AccW'(prod_r) : acc_r + AccW'(prod_r);
    end else if (phase_r == 3'd0) begin
      red_in = AccW'(o_rd);
    end else if (phase_r == 3'd1) begin
      red_in = AccW'(vmod_r) + AccW'(red_rem);
    end
  end

  mst_modred #(.InW(AccW)) u_red (
    .clk(clk), .rst_n(rst_n), .start(cmd.red_start), .din(red_in),
    .q(q_eff), .done(red_done), .rem(red_rem)
  );
  assign sts.red_done = red_done;

  // Final element: forward subtracts the offset, inverse takes the sum as is.
  logic [QW:0] diff;
  assign diff = {1'b0, red_rem} - {1'b0, omod_r};
  always_comb begin
    if (inv) begin
      res_value = red_rem;
    end else if (diff[QW]) begin
      res_value = diff[QW-1:0] + q_eff;
    end else begin
      res_value = diff[QW-1:0];
    end
  end

  assign vwe = (cmd.emit) || (red_done && phase_r == 3'd4 && ok_r && act_r == ACT_VEC);
  assign vwa = cmd.emit ? ei : row_r;
  assign vwd = cmd.emit ? res_value : red_rem;
  assign owe = red_done && phase_r == 3'd4 && ok_r && act_r == ACT_OFF;
  assign mwe = red_done && phase_r == 3'd4 && ok_r && act_r == ACT_MAT;
  assign wwe = cmd.pre_wr;
  assign wwd = inv ? red_rem : vmod_r;

  mst_ram #(.Width(QW), .Depth(MAX_DIM)) u_vec (
    .clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(ei), .rdata(v_rd));
  mst_ram #(.Width(QW), .Depth(MAX_DIM)) u_off (
    .clk(clk), .we(owe), .waddr(row_r), .wdata(red_rem), .raddr(ei), .rdata(o_rd));
  mst_ram #(.Width(QW), .Depth(MAX_DIM * MAX_DIM)) u_mat (
    .clk(clk), .we(mwe), .waddr({row_r, col_r}), .wdata(red_rem),
    .raddr({ei, ej}), .rdata(m_rd));
  mst_ram #(.Width(QW), .Depth(MAX_DIM)) u_work (
    .clk(clk), .we(wwe), .waddr(ei), .wdata(wwd), .raddr(ej), .rdata(w_rd));
endmodule
`default_nettype wire

// ===== sv/mst_ctrl.sv =====
`default_nettype none
`include "modular_secret_transform_defines.svh"
module mst_ctrl import mst_pkg::*; #(
  parameter int MAX_DIM = MaxDim
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    action,
  input  wire logic [DimW-1:0] dim,
  output logic               busy,
  input  wire mst_sts_t      sts,
  output mst_cmd_t           cmd,
  output logic [$clog2(MAX_DIM)-1:0] ei,
  output logic [$clog2(MAX_DIM)-1:0] ej,
  output logic               emit,
  output logic               last
);
  localparam int AW = $clog2(MAX_DIM);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_PRD = 4'd2, S_PV = 4'd3,
    S_PO = 4'd4, S_PS = 4'd5, S_MRD = 4'd6, S_MRED = 4'd7, S_MACC = 4'd8,
    S_MADD = 4'd9, S_FIN = 4'd10, S_EMIT = 4'd11, S_PWAIT = 4'd12,
    S_MOFF = 4'd13, S_MOW = 4'd14;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] ei_r, ei_nxt, ej_r, ej_nxt;
  logic [DimW-1:0] n;
  logic          ilast, jlast;

  assign n = (dim == '0) ? DimW'(1) : ((32'(dim) > MAX_DIM) ? DimW'(MAX_DIM) : dim);
  assign ilast = (DimW'(ei_r) == n - 1'b1);
  assign jlast = (DimW'(ej_r) == n - 1'b1);

  always_comb begin
    st_nxt = st_r;
    ei_nxt = ei_r;
    ej_nxt = ej_r;
    cmd = '0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          ei_nxt = '0;
          ej_nxt = '0;
          if (action == ACT_RUN) begin
            st_nxt = S_PWAIT;
          end else begin
            cmd.load = 1'b1;
            cmd.red_start = 1'b1;
            st_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: if (sts.red_done) st_nxt = S_IDLE;
      // The registered RAM reads for the new element index land in the next cycle.
      S_PWAIT: st_nxt = S_PRD;
      S_PRD: begin
        cmd.pre_rd = 1'b1;
        cmd.red_start = 1'b1;
        st_nxt = S_PV;
      end
      S_PV: if (sts.red_done) begin
        cmd.red_start = 1'b1;
        st_nxt = S_PO;
      end
      S_PO: if (sts.red_done) begin
        cmd.red_start = 1'b1;
        st_nxt = S_PS;
      end
      S_PS: if (sts.red_done) begin
        cmd.pre_wr = 1'b1;
        if (ilast) begin
          ei_nxt = '0;
          st_nxt = S_MRD;
        end else begin
          ei_nxt = ei_r + 1'b1;
          st_nxt = S_PWAIT;
        end
      end
      // Waits for the registered RAM reads; at the start of a row the offset is
      // reduced again before the products are walked.
      S_MRD: begin
        cmd.mac_clr = (ej_r == '0);
        st_nxt = (ej_r == '0) ? S_MOFF : S_MRED;
      end
      S_MOFF: begin
        cmd.off_rd = 1'b1;
        cmd.red_start = 1'b1;
        st_nxt = S_MOW;
      end
      S_MOW: if (sts.red_done) st_nxt = S_MRED;
      S_MRED: begin
        cmd.mac_rd = 1'b1;
        cmd.red_start = 1'b1;
        st_nxt = S_MACC;
      end
      S_MACC: if (sts.red_done) begin
        cmd.mac_acc = 1'b1;
        st_nxt = S_MADD;
      end
      S_MADD: begin
        if (jlast) begin
          cmd.fin = 1'b1;
          cmd.red_start = 1'b1;
          st_nxt = S_FIN;
        end else begin
          cmd.fin = 1'b0;
          ej_nxt = ej_r + 1'b1;
          st_nxt = S_MRD;
        end
      end
      S_FIN: if (sts.red_done) st_nxt = S_EMIT;
      S_EMIT: begin
        cmd.emit = 1'b1;
        ej_nxt = '0;
        if (ilast) begin
          st_nxt = S_IDLE;
        end else begin
          ei_nxt = ei_r + 1'b1;
          st_nxt = S_MRD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ei_r <= '0;
      ej_r <= '0;
    end else begin
      st_r <= st_nxt;
      ei_r <= ei_nxt;
      ej_r <= ej_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign ei = ei_r;
  assign ej = ej_r;
  assign emit = cmd.emit;
  assign last = cmd.emit && ilast;

  `MST_ASSERT_IMP(a_last_emit, last, emit, "last without emit")
  `MST_ASSERT_IMP(a_idle_no_emit, st_r == S_IDLE, !emit, "emit while idle")
  `MST_ASSERT_IMP(a_emit_then, emit && last, ##1 (st_r == S_IDLE), "run did not end")
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import mst_pkg::*;

  localparam longint CycleLimit = 4000000;

  typedef struct {
    logic [5:0]  index;
    logic [14:0] value;
    logic        last;
  } element_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = ACT_MAT;
  logic [5:0]  in_row = '0;
  logic [5:0]  in_col = '0;
  logic [14:0] in_value = '0;
  logic        out_strobe;
  logic [5:0]  out_index;
  logic [14:0] out_result_value;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DIM;
  logic [14:0] cfg_data = '0;

  // Predictor copy of the registers and stores.
  logic [6:0]  dim_reg;
  logic [14:0] mod_reg;
  logic        dir_reg;
  logic [14:0] mat_mem [MaxDim][MaxDim];
  logic [14:0] off_mem [MaxDim];
  logic [14:0] vec_mem [MaxDim];
  bit          mat_set [MaxDim][MaxDim];
  bit          off_set [MaxDim];
  bit          vec_set [MaxDim];

  element_t    pending_elems[$];
  int          errors = 0;
  longint      cycles = 0;

  modular_secret_transform dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .out_strobe(out_strobe), .out_index(out_index),
    .out_result_value(out_result_value), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int unsigned eff_q();
    return (mod_reg < 2) ? 1 : mod_reg;
  endfunction

  function automatic int unsigned eff_n();
    if (dim_reg == 0) return 1;
    if (dim_reg > MaxDim) return MaxDim;
    return dim_reg;
  endfunction

  // Works out the transformed vector and queues one element per row.
  function automatic void predict_transform();
    int unsigned q, n, s, r;
    longint unsigned acc;
    int unsigned work [MaxDim];
    element_t e;
    q = eff_q();
    n = eff_n();
    for (int i = 0; i < n; i++) begin
      s = vec_mem[i] % q;
      if (dir_reg) s = (s + off_mem[i] % q) % q;
      work[i] = s;
    end
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++)
        acc += longint'(mat_mem[i][j] % q) * work[j];
      r = acc % q;
      if (!dir_reg) r = (r + q - off_mem[i] % q) % q;
      vec_mem[i] = r[14:0];
      e.index = i[5:0];
      e.value = r[14:0];
      e.last = (i + 1 == n);
      pending_elems.push_back(e);
    end
  endfunction

  function automatic void predict_item(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                                       logic [14:0] v);
    logic [14:0] red;
    red = v % eff_q();
    case (act)
      ACT_MAT: begin mat_mem[r][c] = red; mat_set[r][c] = 1; end
      ACT_OFF: begin off_mem[r] = red; off_set[r] = 1; end
      ACT_VEC: begin vec_mem[r] = red; vec_set[r] = 1; end
      default: predict_transform();
    endcase
  endfunction

  always @(posedge clk) begin
    element_t e;
    if (rst_n && out_strobe) begin
      if (pending_elems.size() == 0) begin
        $error("unexpected word: index %0d value %0d", out_index, out_result_value);
        errors++;
      end else begin
        e = pending_elems.pop_front();
        if (out_index !== e.index) begin
          $error("index: expected %0d, got %0d", e.index, out_index);
          errors++;
        end
        if (out_result_value !== e.value) begin
          $error("result_value: expected %0d, got %0d", e.value, out_result_value);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic idle(int k);
    @(negedge clk);
    start <= 1'b0;
    repeat (k) @(negedge clk);
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  task automatic random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return;
    if (p < 95) idle($urandom_range(0, 3));
    else idle($urandom_range(20, 80));
  endtask

  // Start stays high on return so that the next word can follow directly.
  task automatic send_word(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                           logic [14:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    do @(posedge clk); while (busy);
    predict_item(act, r, c, v);
  endtask

  // Drain: every expected word back, then a wait longer than a load, then idle.
  task automatic wait_drained();
    idle(0);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DIM: dim_reg = data[6:0];
      REG_MOD: mod_reg = data;
      REG_DIR: dir_reg = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [14:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 15'd0;
      1: return 15'h7fff;
      2: return mod_reg - 1;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // Fills every entry a transform of the current size reads that was never written.
  task automatic fill_unwritten(bit gaps, inout int count);
    int n;
    n = eff_n();
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!mat_set[i][j]) begin
          send_word(ACT_MAT, i, j, rand_value());
          count++;
          if (gaps) random_gap();
        end
    for (int i = 0; i < n; i++) begin
      if (!off_set[i]) begin
        send_word(ACT_OFF, i, $urandom_range(0, 63), rand_value());
        count++;
        if (gaps) random_gap();
      end
      if (!vec_set[i]) begin
        send_word(ACT_VEC, i, $urandom_range(0, 63), rand_value());
        count++;
        if (gaps) random_gap();
      end
    end
  endtask

  task automatic test_directed();
    write_reg(REG_DIM, 15'd2);
    write_reg(REG_MOD, 15'd32767);
    write_reg(REG_DIR, 15'd0);
    send_word(ACT_MAT, 0, 0, 15'h7fff);
    send_word(ACT_MAT, 0, 1, 15'd32766);
    send_word(ACT_MAT, 1, 0, 15'd1);
    send_word(ACT_MAT, 1, 1, 15'd0);
    send_word(ACT_OFF, 0, 63, 15'd0);
    send_word(ACT_OFF, 1, 0, 15'd32766);
    send_word(ACT_VEC, 0, 0, 15'd32766);
    send_word(ACT_VEC, 1, 0, 15'd1);
    send_word(ACT_MAT, 63, 63, 15'h5555);
    send_word(ACT_RUN, 63, 63, 15'h7fff);
    wait_drained();
    write_reg(REG_DIR, 15'd1);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
    // The modulus shrinks after loading, so stored operands get reduced again.
    write_reg(REG_MOD, 15'd2);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
    write_reg(REG_MOD, 15'd0);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
    write_reg(REG_MOD, 15'd1);
    send_word(ACT_VEC, 0, 0, 15'h2aaa);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
    write_reg(2'd3, 15'h7fff);
    write_reg(REG_DIM, 15'd0);
    write_reg(REG_MOD, 15'd32749);
    write_reg(REG_DIR, 15'd0);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
  endtask

  task automatic test_wide_size();
    int count;
    count = 0;
    write_reg(REG_DIM, 15'd12);
    write_reg(REG_MOD, 15'd32749);
    write_reg(REG_DIR, 15'd0);
    fill_unwritten(0, count);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
    write_reg(REG_DIR, 15'd1);
    send_word(ACT_RUN, 0, 0, 15'd0);
    wait_drained();
  endtask

  task automatic test_random();
    int count;
    count = 0;
    while (count < 320) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_DIM, $urandom_range(1, 8));
      else if ($urandom_range(0, 9) == 0) write_reg(REG_DIM, 0);
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_MOD, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(2, 32767));
      if ($urandom_range(0, 1) == 0) write_reg(REG_DIR, $urandom_range(0, 1));
      fill_unwritten(1, count);
      repeat ($urandom_range(4, 14)) begin
        if ($urandom_range(0, 3) == 0)
          send_word(ACT_RUN, $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
        else
          send_word($urandom_range(0, 2), $urandom_range(0, 63), $urandom_range(0, 63),
                    rand_value());
        count++;
        random_gap();
      end
      wait_drained();
    end
  endtask

  initial begin
    dim_reg = 7'd64;
    mod_reg = 15'd32749;
    dir_reg = 1'b0;
    foreach (mat_set[i, j]) mat_set[i][j] = 0;
    foreach (off_set[i]) begin
      off_set[i] = 0;
      vec_set[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_directed();
    test_random();
    test_wide_size();
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
